[hdl/xsvf_pkg.sv]
// shared types, constants and helper functions for the xsvf stream parser
// no dependencies
`default_nettype none

package xsvf_pkg;

  // longest vector, in bytes, that the scan chain can hold
  localparam int MAX_CHAIN_BYTES = 128;

  // byte counter width: holds a full vector length, the 4-byte numeric arguments
  // and a comment position wide enough for the 7-bit index wrap
  localparam int CNT_W = ($clog2(MAX_CHAIN_BYTES + 1) > 7) ? $clog2(MAX_CHAIN_BYTES + 1) : 7;

  // opcodes
  localparam logic [4:0] OP_XCOMPLETE    = 5'd0;
  localparam logic [4:0] OP_XTDOMASK     = 5'd1;
  localparam logic [4:0] OP_XSIR         = 5'd2;
  localparam logic [4:0] OP_XSDR         = 5'd3;
  localparam logic [4:0] OP_XRUNTEST     = 5'd4;
  localparam logic [4:0] OP_RSVD5        = 5'd5;
  localparam logic [4:0] OP_RSVD6        = 5'd6;
  localparam logic [4:0] OP_XREPEAT      = 5'd7;
  localparam logic [4:0] OP_XSDRSIZE     = 5'd8;
  localparam logic [4:0] OP_XSDRTDO      = 5'd9;
  localparam logic [4:0] OP_XSETSDRMASKS = 5'd10;
  localparam logic [4:0] OP_XSDRINC      = 5'd11;
  localparam logic [4:0] OP_XSDRB        = 5'd12;
  localparam logic [4:0] OP_XSDRC        = 5'd13;
  localparam logic [4:0] OP_XSDRE        = 5'd14;
  localparam logic [4:0] OP_XSDRTDOB     = 5'd15;
  localparam logic [4:0] OP_XSDRTDOC     = 5'd16;
  localparam logic [4:0] OP_XSDRTDOE     = 5'd17;
  localparam logic [4:0] OP_XSTATE       = 5'd18;
  localparam logic [4:0] OP_XENDIR       = 5'd19;
  localparam logic [4:0] OP_XENDDR       = 5'd20;
  localparam logic [4:0] OP_XSIR2        = 5'd21;
  localparam logic [4:0] OP_XCOMMENT     = 5'd22;
  localparam logic [4:0] OP_XWAIT        = 5'd23;
  localparam logic [7:0] OP_LAST         = 8'd23;

  // tap state codes
  localparam logic [3:0] TAP_RTI      = 4'd1;
  localparam logic [3:0] TAP_PAUSE_DR = 4'd6;
  localparam logic [3:0] TAP_PAUSE_IR = 4'd13;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNK_OP  = 3'd1,
    ERR_IR_LONG = 3'd2,
    ERR_DR_LONG = 3'd3,
    ERR_END_ST  = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_ARG1    = 3'd1,
    PH_ARG2    = 3'd2,
    PH_ARG3    = 3'd3,
    PH_VEC1    = 3'd4,
    PH_VEC2    = 3'd5,
    PH_COMMENT = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  // parser control state
  typedef struct packed {
    phase_t phase;
    err_t   err;
    logic   cplt;
  } ctl_t;

  // counters, argument accumulator and instruction registers
  typedef struct packed {
    logic [4:0]       opcode;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      acc;
    logic [15:0]      ir_len;
    logic [31:0]      dr_len;
    logic [7:0]       rpt;
    logic [31:0]      run_test;
    logic [3:0]       end_ir;
    logic [3:0]       end_dr;
    logic [7:0]       next_tap;
    logic [7:0]       wait_start;
    logic [7:0]       wait_end;
    logic [31:0]      wait_us;
    logic [31:0]      sum;
  } dat_t;

  // one result token
  typedef struct packed {
    logic [4:0]  instruction;
    logic [1:0]  byte_role;
    logic [7:0]  data_byte;
    logic [6:0]  vector_index;
    logic [31:0] argument_value;
    logic        instruction_done;
    logic [2:0]  fault_code;
    logic        complete;
    logic [31:0] stream_sum;
  } res_t;

  // bit length rounded up to whole bytes
  function automatic logic [32:0] bytes_of(input logic [31:0] bits);
    logic [32:0] sum;
    sum = {1'b0, bits} + 33'd7;
    return sum >> 3;
  endfunction

  function automatic logic is_ir_op(input logic [4:0] op);
    return (op == OP_XSIR) || (op == OP_XSIR2);
  endfunction

  function automatic logic is_two_vector(input logic [4:0] op);
    return (op == OP_XSDRTDO) || (op == OP_XSETSDRMASKS) || (op == OP_XSDRTDOB) ||
           (op == OP_XSDRTDOC) || (op == OP_XSDRTDOE);
  endfunction

  function automatic logic is_dr_vector_op(input logic [4:0] op);
    return (op == OP_XTDOMASK) || (op == OP_XSDR) || (op == OP_XSDRTDO) ||
           (op == OP_XSETSDRMASKS) || (op == OP_XSDRB) || (op == OP_XSDRC) ||
           (op == OP_XSDRE) || (op == OP_XSDRTDOB) || (op == OP_XSDRTDOC) ||
           (op == OP_XSDRTDOE);
  endfunction

  function automatic logic is_numeric_op(input logic [4:0] op);
    return (op == OP_XSIR) || (op == OP_XRUNTEST) || (op == OP_XREPEAT) ||
           (op == OP_XSDRSIZE) || (op == OP_XSTATE) || (op == OP_XENDIR) ||
           (op == OP_XENDDR) || (op == OP_XSIR2) || (op == OP_XWAIT);
  endfunction

  // byte count of the numeric argument being read in the given phase
  function automatic logic [2:0] numeric_len(input logic [4:0] op, input phase_t ph);
    logic [2:0] len;
    len = 3'd1;
    if ((op == OP_XRUNTEST) || (op == OP_XSDRSIZE)) begin
      len = 3'd4;
    end else if (op == OP_XSIR2) begin
      len = 3'd2;
    end else if ((op == OP_XWAIT) && (ph == PH_ARG3)) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

[hdl/xsvf_instruction_stream_parser_core.sv]
// xsvf stream parser top level: input register, parser state, result register
// a request accepted into the input register moves on into the result register and then shows on out_valid
// throughput: one byte per cycle while the receiver does not stall, set by the single-pass parse step between registers
// reset: synchronous active-low rst_n empties both registers and returns the parser
// to expect-opcode with repeat 32, end states run-test/idle and all else cleared
// depends on xsvf_pkg and xsvf_step
`default_nettype none

module xsvf_instruction_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_instruction,
  output logic [1:0]       out_byte_role,
  output logic [7:0]       out_data_byte,
  output logic [6:0]       out_vector_index,
  output logic [31:0]      out_argument_value,
  output logic             out_instruction_done,
  output logic [2:0]       out_fault_code,
  output logic             out_complete,
  output logic [31:0]      out_stream_sum
);
  import xsvf_pkg::*;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // parser state
  ctl_t ctl_r, ctl_nxt;
  dat_t dat_r, dat_nxt;

  // result register
  logic out_vld_r;
  res_t res_r, res_nxt;

  // the held request moves into the result register when that slot is free
  // or its token is being taken this cycle
  logic adv;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  xsvf_step u_step (
    .ctl         (ctl_r),
    .dat         (dat_r),
    .stream_byte (in_byte_r),
    .ctl_nxt     (ctl_nxt),
    .dat_nxt     (dat_nxt),
    .res         (res_nxt)
  );

  // input register: refills whenever it is not holding a stalled request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_stream_byte;
    end
  end

  // parser state advances once per request that reaches the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_OPCODE;
      ctl_r.err        <= ERR_NONE;
      ctl_r.cplt       <= 1'b0;
      dat_r.opcode     <= '0;
      dat_r.cnt        <= '0;
      dat_r.acc        <= '0;
      dat_r.ir_len     <= '0;
      dat_r.dr_len     <= '0;
      dat_r.rpt        <= 8'd32;
      dat_r.run_test   <= '0;
      dat_r.end_ir     <= TAP_RTI;
      dat_r.end_dr     <= TAP_RTI;
      dat_r.next_tap   <= '0;
      dat_r.wait_start <= '0;
      dat_r.wait_end   <= '0;
      dat_r.wait_us    <= '0;
      dat_r.sum        <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
      dat_r <= dat_nxt;
    end
  end

  // result register: holds its token while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_instruction      = res_r.instruction;
  assign out_byte_role        = res_r.byte_role;
  assign out_data_byte        = res_r.data_byte;
  assign out_vector_index     = res_r.vector_index;
  assign out_argument_value   = res_r.argument_value;
  assign out_instruction_done = res_r.instruction_done;
  assign out_fault_code       = res_r.fault_code;
  assign out_complete         = res_r.complete;
  assign out_stream_sum       = res_r.stream_sum;

  // a request that advances from the input register always lands in the result register next
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced request did not reach the result register");

  // the input side only stalls while a request is held
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with no request held");

  // completion is sticky across delivered tokens
  a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.complete) |=> (!out_vld_r || res_r.complete))
    else $error("complete flag dropped");

  // an error code never changes once reported
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.fault_code != ERR_NONE)) |=>
      (!out_vld_r || (res_r.fault_code == $past(res_r.fault_code))))
    else $error("sticky error changed");

endmodule

`default_nettype wire

[hdl/xsvf_step.sv]
// per-byte parse step: next parser state and the result token for one stream byte
// depends on xsvf_pkg
`default_nettype none

module xsvf_step (
  input  wire xsvf_pkg::ctl_t ctl,
  input  wire xsvf_pkg::dat_t dat,
  input  wire logic [7:0]     stream_byte,
  output xsvf_pkg::ctl_t      ctl_nxt,
  output xsvf_pkg::dat_t      dat_nxt,
  output xsvf_pkg::res_t      res
);
  import xsvf_pkg::*;

  logic [4:0]       op_in;
  logic             bad_op;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      acc_shift;
  logic             arg_last;
  logic [32:0]      ir_bytes_new;
  logic [32:0]      dr_bytes_new;
  logic             ir_too_long;
  logic             dr_too_long;
  logic [32:0]      dr_bytes_cur;
  logic [32:0]      vec_len;
  logic             vec_last;
  logic             is_wait;

  assign op_in     = stream_byte[4:0];
  assign bad_op    = (stream_byte > OP_LAST) || (op_in == OP_RSVD5) ||
                     (op_in == OP_RSVD6) || (op_in == OP_XSDRINC);
  assign cnt_inc   = dat.cnt + CNT_W'(1);
  assign acc_shift = {dat.acc[23:0], stream_byte};
  assign arg_last  = cnt_inc >= CNT_W'(numeric_len(dat.opcode, ctl.phase));
  assign is_wait   = dat.opcode == OP_XWAIT;

  assign ir_bytes_new = bytes_of({16'd0, acc_shift[15:0]});
  assign dr_bytes_new = bytes_of(acc_shift);
  assign ir_too_long  = ir_bytes_new > 33'(MAX_CHAIN_BYTES);
  assign dr_too_long  = dr_bytes_new > 33'(MAX_CHAIN_BYTES);

  assign dr_bytes_cur = bytes_of(dat.dr_len);
  assign vec_len      = is_ir_op(dat.opcode) ? bytes_of({16'd0, dat.ir_len}) : dr_bytes_cur;
  assign vec_last     = 33'(cnt_inc) >= vec_len;

  // next phase, sticky error and completion
  always_comb begin
    ctl_nxt = ctl;
    case (ctl.phase)
      PH_OPCODE: begin
        if (bad_op) begin
          ctl_nxt.err   = ERR_UNK_OP;
          ctl_nxt.phase = PH_HALT;
        end else if (op_in == OP_XCOMPLETE) begin
          ctl_nxt.cplt  = 1'b1;
          ctl_nxt.phase = PH_HALT;
        end else if (op_in == OP_XCOMMENT) begin
          ctl_nxt.phase = PH_COMMENT;
        end else if (is_numeric_op(op_in)) begin
          ctl_nxt.phase = PH_ARG1;
        end else if (is_dr_vector_op(op_in) && (dr_bytes_cur != 33'd0)) begin
          ctl_nxt.phase = PH_VEC1;
        end
      end
      PH_ARG1, PH_ARG2, PH_ARG3: begin
        if (arg_last) begin
          if (is_wait && (ctl.phase == PH_ARG1)) begin
            ctl_nxt.phase = PH_ARG2;
          end else if (is_wait && (ctl.phase == PH_ARG2)) begin
            ctl_nxt.phase = PH_ARG3;
          end else begin
            ctl_nxt.phase = PH_OPCODE;
            if ((dat.opcode == OP_XSDRSIZE) && dr_too_long) begin
              ctl_nxt.err   = ERR_DR_LONG;
              ctl_nxt.phase = PH_HALT;
            end else if (((dat.opcode == OP_XENDIR) || (dat.opcode == OP_XENDDR)) &&
                         (stream_byte > 8'd1)) begin
              ctl_nxt.err   = ERR_END_ST;
              ctl_nxt.phase = PH_HALT;
            end else if (is_ir_op(dat.opcode)) begin
              if (ir_too_long) begin
                ctl_nxt.err   = ERR_IR_LONG;
                ctl_nxt.phase = PH_HALT;
              end else if (ir_bytes_new != 33'd0) begin
                ctl_nxt.phase = PH_VEC2;
              end
            end
          end
        end
      end
      PH_VEC1, PH_VEC2: begin
        if (vec_last) begin
          if ((ctl.phase == PH_VEC1) && is_two_vector(dat.opcode)) begin
            ctl_nxt.phase = PH_VEC2;
          end else begin
            ctl_nxt.phase = PH_OPCODE;
          end
        end
      end
      PH_COMMENT: begin
        if (stream_byte == 8'd0) begin
          ctl_nxt.phase = PH_OPCODE;
        end
      end
      default: begin
        ctl_nxt.phase = PH_HALT;
      end
    endcase
  end

  // data registers and result token
  always_comb begin
    dat_nxt     = dat;
    dat_nxt.sum = dat.sum + {24'd0, stream_byte};

    res                  = '0;
    res.instruction      = dat.opcode;
    res.data_byte        = stream_byte;
    res.fault_code       = ctl_nxt.err;
    res.complete         = ctl_nxt.cplt;
    res.stream_sum       = dat_nxt.sum;

    case (ctl.phase)
      PH_OPCODE: begin
        res.instruction      = op_in;
        dat_nxt.opcode       = op_in;
        dat_nxt.cnt          = '0;
        dat_nxt.acc          = '0;
        res.instruction_done = bad_op || (op_in == OP_XCOMPLETE) ||
                               ((op_in != OP_XCOMMENT) && !is_numeric_op(op_in) &&
                                is_dr_vector_op(op_in) && (dr_bytes_cur == 33'd0));
      end
      PH_ARG1, PH_ARG2, PH_ARG3: begin
        res.byte_role      = 2'(ctl.phase);
        res.argument_value = acc_shift;
        res.vector_index   = 7'(dat.cnt);
        dat_nxt.acc        = acc_shift;
        dat_nxt.cnt        = cnt_inc;
        if (arg_last) begin
          dat_nxt.cnt = '0;
          dat_nxt.acc = '0;
          if (is_wait && (ctl.phase == PH_ARG1)) begin
            dat_nxt.wait_start = stream_byte;
          end else if (is_wait && (ctl.phase == PH_ARG2)) begin
            dat_nxt.wait_end = stream_byte;
          end else begin
            res.instruction_done = 1'b1;
            case (dat.opcode)
              OP_XRUNTEST: dat_nxt.run_test = acc_shift;
              OP_XREPEAT:  dat_nxt.rpt      = stream_byte;
              OP_XSDRSIZE: dat_nxt.dr_len   = acc_shift;
              OP_XSTATE:   dat_nxt.next_tap = stream_byte;
              OP_XENDIR: begin
                if (stream_byte == 8'd0) begin
                  dat_nxt.end_ir = TAP_RTI;
                end else if (stream_byte == 8'd1) begin
                  dat_nxt.end_ir = TAP_PAUSE_IR;
                end
              end
              OP_XENDDR: begin
                if (stream_byte == 8'd0) begin
                  dat_nxt.end_dr = TAP_RTI;
                end else if (stream_byte == 8'd1) begin
                  dat_nxt.end_dr = TAP_PAUSE_DR;
                end
              end
              OP_XWAIT:    dat_nxt.wait_us = acc_shift;
              OP_XSIR, OP_XSIR2: begin
                dat_nxt.ir_len       = acc_shift[15:0];
                res.instruction_done = ir_too_long || (ir_bytes_new == 33'd0);
              end
              default: begin
                dat_nxt.acc = '0;
              end
            endcase
          end
        end
      end
      PH_VEC1, PH_VEC2: begin
        res.byte_role    = (ctl.phase == PH_VEC1) ? 2'd1 : 2'd2;
        res.vector_index = 7'(dat.cnt);
        dat_nxt.cnt      = cnt_inc;
        if (vec_last) begin
          dat_nxt.cnt          = '0;
          res.instruction_done = !((ctl.phase == PH_VEC1) && is_two_vector(dat.opcode));
        end
      end
      PH_COMMENT: begin
        res.byte_role    = 2'd1;
        res.vector_index = 7'(dat.cnt);
        dat_nxt.cnt      = cnt_inc;
        if (stream_byte == 8'd0) begin
          res.instruction_done = 1'b1;
          dat_nxt.cnt          = '0;
        end
      end
      default: begin
        res.byte_role = 2'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for xsvf_instruction_stream_parser_core: feeds xsvf byte streams
// with random content and random gaps on both sides, checks every result token in order
// depends on xsvf_pkg and the parser rtl
module testbench;
  import xsvf_pkg::*;

  // watchdog: cycles with no request moving on either channel
  localparam int IDLE_LIMIT = 2000;
  // stream length before the closing halt and the halted tail
  localparam int STREAM_BYTES = 1300;
  // largest legal chain, in bits
  localparam int CHAIN_BITS = MAX_CHAIN_BYTES * 8;

  // every opcode that keeps the parser running
  localparam logic [4:0] RUN_OPS [20] = '{
    OP_XTDOMASK, OP_XSIR, OP_XSDR, OP_XRUNTEST, OP_XREPEAT, OP_XSDRSIZE, OP_XSDRTDO,
    OP_XSETSDRMASKS, OP_XSDRB, OP_XSDRC, OP_XSDRE, OP_XSDRTDOB, OP_XSDRTDOC,
    OP_XSDRTDOE, OP_XSTATE, OP_XENDIR, OP_XENDDR, OP_XSIR2, OP_XCOMMENT, OP_XWAIT
  };

  // parse state mirror plus the queue of tokens still owed by the block
  class xsvf_token_board;
    phase_t      phase;
    err_t        err;
    logic        cplt;
    logic [4:0]  opcode;
    logic [15:0] cnt;
    logic [31:0] acc;
    logic [15:0] ir_bits;
    logic [31:0] dr_bits;
    logic [7:0]  rpt;
    logic [31:0] run_test;
    logic [3:0]  end_ir;
    logic [3:0]  end_dr;
    logic [7:0]  next_tap;
    logic [7:0]  wait_start;
    logic [7:0]  wait_end;
    logic [31:0] wait_us;
    logic [31:0] sum;
    res_t        tokens_due[$];
    int          mismatches;
    int          tokens_seen;

    function new();
      phase = PH_OPCODE;
      err = ERR_NONE;
      cplt = 1'b0;
      opcode = 5'd0;
      cnt = 16'd0;
      acc = 32'd0;
      ir_bits = 16'd0;
      dr_bits = 32'd0;
      rpt = 8'd32;
      run_test = 32'd0;
      end_ir = TAP_RTI;
      end_dr = TAP_RTI;
      next_tap = 8'd0;
      wait_start = 8'd0;
      wait_end = 8'd0;
      wait_us = 32'd0;
      sum = 32'd0;
      mismatches = 0;
      tokens_seen = 0;
    endfunction

    function logic [16:0] ir_vec_bytes();
      return ({1'b0, ir_bits} + 17'd7) >> 3;
    endfunction

    function logic [32:0] dr_vec_bytes();
      return ({1'b0, dr_bits} + 33'd7) >> 3;
    endfunction

    function int arg_bytes(logic [4:0] op, phase_t ph);
      case (op)
        OP_XRUNTEST, OP_XSDRSIZE: return 4;
        OP_XSIR2: return 2;
        OP_XWAIT: return (ph == PH_ARG3) ? 4 : 1;
        default: return 1;
      endcase
    endfunction

    function void stop_on(err_t code);
      err = code;
      phase = PH_HALT;
    endfunction

    // one accepted stream byte: advance the parse and queue the token it owes
    function void take_byte(logic [7:0] b);
      res_t        tok;
      logic [4:0]  op;
      logic [1:0]  role;
      logic [15:0] idx;
      logic [31:0] arg;
      logic        done;
      logic [32:0] vlen;
      op = opcode;
      role = 2'd0;
      idx = 16'd0;
      arg = 32'd0;
      done = 1'b0;
      sum = sum + {24'd0, b};
      case (phase)
        PH_OPCODE: begin
          op = b[4:0];
          opcode = op;
          cnt = 16'd0;
          acc = 32'd0;
          if (b > OP_LAST || op == OP_RSVD5 || op == OP_RSVD6 || op == OP_XSDRINC) begin
            done = 1'b1;
            stop_on(ERR_UNK_OP);
          end else if (op == OP_XCOMPLETE) begin
            cplt = 1'b1;
            done = 1'b1;
            phase = PH_HALT;
          end else if (op == OP_XCOMMENT) begin
            phase = PH_COMMENT;
          end else if (op inside {OP_XSIR, OP_XRUNTEST, OP_XREPEAT, OP_XSDRSIZE, OP_XSTATE,
                                  OP_XENDIR, OP_XENDDR, OP_XSIR2, OP_XWAIT}) begin
            phase = PH_ARG1;
          end else if (dr_vec_bytes() == 33'd0) begin
            done = 1'b1;
          end else begin
            phase = PH_VEC1;
          end
        end
        PH_ARG1, PH_ARG2, PH_ARG3: begin
          role = phase[1:0];
          acc = {acc[23:0], b};
          arg = acc;
          idx = cnt;
          cnt = cnt + 16'd1;
          if (int'(cnt) >= arg_bytes(op, phase)) begin
            cnt = 16'd0;
            acc = 32'd0;
            if (op == OP_XWAIT && phase == PH_ARG1) begin
              wait_start = b;
              phase = PH_ARG2;
            end else if (op == OP_XWAIT && phase == PH_ARG2) begin
              wait_end = b;
              phase = PH_ARG3;
            end else begin
              done = 1'b1;
              phase = PH_OPCODE;
              case (op)
                OP_XRUNTEST: run_test = arg;
                OP_XREPEAT: rpt = b;
                OP_XSDRSIZE: begin
                  dr_bits = arg;
                  if (dr_vec_bytes() > 33'(MAX_CHAIN_BYTES)) stop_on(ERR_DR_LONG);
                end
                OP_XSTATE: next_tap = b;
                OP_XENDIR, OP_XENDDR: begin
                  if (b > 8'd1) stop_on(ERR_END_ST);
                  else if (op == OP_XENDIR) end_ir = b[0] ? TAP_PAUSE_IR : TAP_RTI;
                  else end_dr = b[0] ? TAP_PAUSE_DR : TAP_RTI;
                end
                OP_XWAIT: wait_us = arg;
                default: begin
                  // xsir and xsir2: the vector follows the size in the same instruction
                  ir_bits = arg[15:0];
                  if (ir_vec_bytes() > 17'(MAX_CHAIN_BYTES)) begin
                    stop_on(ERR_IR_LONG);
                  end else if (ir_vec_bytes() != 17'd0) begin
                    done = 1'b0;
                    phase = PH_VEC2;
                  end
                end
              endcase
            end
          end
        end
        PH_VEC1, PH_VEC2: begin
          role = (phase == PH_VEC1) ? 2'd1 : 2'd2;
          idx = cnt;
          cnt = cnt + 16'd1;
          vlen = (op == OP_XSIR || op == OP_XSIR2) ? {16'd0, ir_vec_bytes()} : dr_vec_bytes();
          if ({17'd0, cnt} >= vlen) begin
            cnt = 16'd0;
            if (phase == PH_VEC1 && op inside {OP_XSDRTDO, OP_XSETSDRMASKS, OP_XSDRTDOB,
                                               OP_XSDRTDOC, OP_XSDRTDOE}) begin
              phase = PH_VEC2;
            end else begin
              done = 1'b1;
              phase = PH_OPCODE;
            end
          end
        end
        PH_COMMENT: begin
          role = 2'd1;
          idx = cnt;
          cnt = cnt + 16'd1;
          if (b == 8'd0) begin
            done = 1'b1;
            cnt = 16'd0;
            phase = PH_OPCODE;
          end
        end
        default: ;
      endcase
      tok.instruction = op;
      tok.byte_role = role;
      tok.data_byte = b;
      tok.vector_index = idx[6:0];
      tok.argument_value = arg;
      tok.instruction_done = done;
      tok.fault_code = err;
      tok.complete = cplt;
      tok.stream_sum = sum;
      tokens_due.push_back(tok);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got === want) return;
      mismatches++;
      if (mismatches <= 10)
        $display("token %0d: %s expected %0h, got %0h", tokens_seen, field, want, got);
    endfunction

    // one accepted result token against the oldest one owed
    function void check_token(res_t got);
      res_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token with nothing owed: data_byte %0h, stream_sum %0h",
                   got.data_byte, got.stream_sum);
        return;
      end
      want = tokens_due.pop_front();
      compare("instruction", 32'(want.instruction), 32'(got.instruction));
      compare("byte_role", 32'(want.byte_role), 32'(got.byte_role));
      compare("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      compare("vector_index", 32'(want.vector_index), 32'(got.vector_index));
      compare("argument_value", want.argument_value, got.argument_value);
      compare("instruction_done", 32'(want.instruction_done), 32'(got.instruction_done));
      compare("fault_code", 32'(want.fault_code), 32'(got.fault_code));
      compare("complete", 32'(want.complete), 32'(got.complete));
      compare("stream_sum", want.stream_sum, got.stream_sum);
      tokens_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_instruction;
  logic [1:0]  out_byte_role;
  logic [7:0]  out_data_byte;
  logic [6:0]  out_vector_index;
  logic [31:0] out_argument_value;
  logic        out_instruction_done;
  logic [2:0]  out_fault_code;
  logic        out_complete;
  logic [31:0] out_stream_sum;

  xsvf_token_board board;
  res_t            token_seen;
  int              bytes_sent = 0;
  // when set, that side runs without idling for a while
  bit              in_calm = 1'b0;
  bit              out_calm = 1'b0;
  // byte lengths of the chains the stream has set up so far
  int              chain_ir_bytes = 0;
  int              chain_dr_bytes = 0;

  xsvf_instruction_stream_parser_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_stream_byte       (in_stream_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_instruction      (out_instruction),
    .out_byte_role        (out_byte_role),
    .out_data_byte        (out_data_byte),
    .out_vector_index     (out_vector_index),
    .out_argument_value   (out_argument_value),
    .out_instruction_done (out_instruction_done),
    .out_fault_code       (out_fault_code),
    .out_complete         (out_complete),
    .out_stream_sum       (out_stream_sum)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pause_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // chain length in bits: small mostly, with the empty and the full chain now and then
  function automatic int chain_bits(int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 10) return top;
    if (r < 22) return $urandom_range(0, top);
    return $urandom_range(1, 40);
  endfunction

  // switch the calm stretches on and off at random intervals
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(negedge clk);
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // result side back-pressure, changed only on falling edges
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      n = pause_len(out_calm);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  end

  // every accepted result token goes to the board, sampled before the edge updates
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      token_seen.instruction = out_instruction;
      token_seen.byte_role = out_byte_role;
      token_seen.data_byte = out_data_byte;
      token_seen.vector_index = out_vector_index;
      token_seen.argument_value = out_argument_value;
      token_seen.instruction_done = out_instruction_done;
      token_seen.fault_code = out_fault_code;
      token_seen.complete = out_complete;
      token_seen.stream_sum = out_stream_sum;
      board.check_token(token_seen);
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one stream byte request; called and returns on a falling edge
  task automatic send_byte(input logic [7:0] b);
    int n;
    in_valid = 1'b1;
    in_stream_byte = b;
    do @(posedge clk); while (in_stall);
    board.take_byte(b);
    bytes_sent++;
    @(negedge clk);
    n = pause_len(in_calm);
    if (n > 0) begin
      in_valid = 1'b0;
      in_stream_byte = 8'($urandom_range(0, 255));
      repeat (n) @(negedge clk);
    end
  endtask

  // numeric argument, most significant byte first
  task automatic send_value(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_fill(input int nbytes);
    repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
  endtask

  // sender holds off until every owed token has come back
  task automatic await_drain();
    in_valid = 1'b0;
    while (board.tokens_due.size() != 0) @(negedge clk);
  endtask

  // one well-formed instruction with random content
  task automatic issue_instruction(input logic [4:0] op);
    int bits;
    int n;
    send_byte({3'd0, op});
    case (op)
      OP_XSIR, OP_XSIR2: begin
        // xsir has a one-byte size and so can never overflow the chain
        bits = chain_bits((op == OP_XSIR) ? 255 : CHAIN_BITS);
        send_value(bits, (op == OP_XSIR) ? 1 : 2);
        chain_ir_bytes = (bits + 7) / 8;
        send_fill(chain_ir_bytes);
      end
      OP_XSDRSIZE: begin
        bits = chain_bits(CHAIN_BITS);
        send_value(bits, 4);
        chain_dr_bytes = (bits + 7) / 8;
      end
      OP_XRUNTEST: send_value($urandom, 4);
      OP_XREPEAT, OP_XSTATE: send_value($urandom_range(0, 255), 1);
      OP_XENDIR, OP_XENDDR: send_value($urandom_range(0, 1), 1);
      OP_XWAIT: begin
        send_value($urandom_range(0, 255), 1);
        send_value($urandom_range(0, 255), 1);
        send_value($urandom, 4);
      end
      OP_XCOMMENT: begin
        // a long comment now and then walks the index past its wrap
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 200) : $urandom_range(0, 12);
        repeat (n) send_byte(8'($urandom_range(1, 255)));
        send_byte(8'd0);
      end
      default: begin
        // data register vectors: tdo/mask forms carry two of them
        if (op inside {OP_XSDRTDO, OP_XSETSDRMASKS, OP_XSDRTDOB, OP_XSDRTDOC, OP_XSDRTDOE})
          send_fill(2 * chain_dr_bytes);
        else
          send_fill(chain_dr_bytes);
      end
    endcase
  endtask

  initial begin
    board = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed opening: empty chains, end states, extreme values, empty comment
    send_byte(8'(OP_XSDRSIZE));
    send_value(32'd0, 4);
    // empty data vector ends on the opcode itself
    send_byte(8'(OP_XSDR));
    // empty ir vector ends on the size byte
    send_byte(8'(OP_XSIR));
    send_byte(8'd0);
    send_byte(8'(OP_XENDIR));
    send_byte(8'd1);
    send_byte(8'(OP_XENDDR));
    send_byte(8'd0);
    send_byte(8'(OP_XSDRSIZE));
    send_value(32'd8, 4);
    send_byte(8'(OP_XSDRTDO));
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'(OP_XRUNTEST));
    send_value(32'hffff_ffff, 4);
    send_byte(8'(OP_XCOMMENT));
    send_byte(8'd0);
    chain_dr_bytes = 1;
    chain_ir_bytes = 0;
    await_drain();

    // random instruction stream, with an occasional full drain
    while (bytes_sent < STREAM_BYTES) begin
      issue_instruction(RUN_OPS[5'($urandom_range(0, 19))]);
      if ($urandom_range(0, 59) == 0) await_drain();
    end

    // close with one halting event, then bytes the halted parser only sums
    case ($urandom_range(0, 5))
      0: send_byte(8'(OP_XCOMPLETE));
      1: begin
        case ($urandom_range(0, 3))
          0: send_byte(8'(OP_RSVD5));
          1: send_byte(8'(OP_RSVD6));
          2: send_byte(8'(OP_XSDRINC));
          default: send_byte(8'($urandom_range(24, 255)));
        endcase
      end
      2: begin
        // ir size one bit past the chain, or anywhere above it
        send_byte(8'(OP_XSIR2));
        send_value($urandom_range(0, 1) ? CHAIN_BITS + 1 : $urandom_range(CHAIN_BITS + 1, 65535),
                   2);
      end
      3: begin
        send_byte(8'(OP_XSDRSIZE));
        send_value($urandom_range(0, 1) ? 32'hffff_ffff : CHAIN_BITS + 1 + $urandom_range(0, 9),
                   4);
      end
      4: begin
        send_byte(8'(OP_XENDIR));
        send_byte(8'($urandom_range(2, 255)));
      end
      default: begin
        send_byte(8'(OP_XENDDR));
        send_byte(8'($urandom_range(2, 255)));
      end
    endcase
    send_fill($urandom_range(20, 50));

    await_drain();
    // keep watching after the drain to catch any token the block should not send
    repeat (10) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[xsvf_instruction_stream_parser_core.f]
hdl/xsvf_pkg.sv
hdl/xsvf_step.sv
hdl/xsvf_instruction_stream_parser_core.sv
tb/testbench.sv
